/* src/mlfd_pkg.sv */
`default_nettype none

package mlfd_pkg;

  // Widths fixed by the frame format and register map
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MagicW   = 32;
  localparam int unsigned MaxLenW  = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned KindW    = 2;

  // Default ceiling on the length field
  localparam int unsigned DefMaxFrameLen = 65536;

  // Reset value of the max_length register
  localparam logic [MaxLenW-1:0] MaxLenRst = MaxLenW'(65536);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BEGIN_MAGIC = 2'd0,
    CFG_END_MAGIC   = 2'd1,
    CFG_MAX_LENGTH  = 2'd2
  } cfg_idx_e;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_e;

  // One result word
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] frame_type;
    logic             frame_end;
  } result_t;

endpackage

`default_nettype wire

/* src/mlfd_if.sv */
`default_nettype none

// Byte stream channel
interface mlfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [mlfd_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// Result channel
interface mlfd_out_if;
  logic                       valid;
  logic                       ready;
  logic [mlfd_pkg::KindW-1:0] kind;
  logic [mlfd_pkg::ByteW-1:0] value;
  logic [mlfd_pkg::ByteW-1:0] frame_type;
  logic                       frame_end;

  modport source (output valid, output kind, output value, output frame_type,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input value, input frame_type,
                  input frame_end, output ready);
endinterface

`default_nettype wire

/* src/magic_length_frame_deframer_core.sv */
// Frame deframer: takes one stream byte per cycle, hunts for the begin magic,
// reads the 32-bit big-endian length and the type byte, forwards each payload
// byte as a result word and closes the frame with a status word (good, end
// magic mismatch or bad length). Each byte is handled by the combinational
// phase logic, with the result going to an output register backed by a
// one-word skid register, so one byte per cycle is sustained whenever results
// are taken; the input stalls only while both of those registers are full.
// Configuration writes are meant for idle periods and act on the next compare.
`default_nettype none

module magic_length_frame_deframer_core #(
  parameter int unsigned MAX_FRAME_LEN = mlfd_pkg::DefMaxFrameLen
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [mlfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mlfd_pkg::CfgDataW-1:0] cfg_data_i,
  // streams
  mlfd_in_if.sink                            in_i,
  mlfd_out_if.source                         out_o
);

  localparam logic [mlfd_pkg::MagicW-1:0] FrameLenCap =
      mlfd_pkg::MagicW'(MAX_FRAME_LEN);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_ENDMAG  = 3'd4
  } phase_e;

  // Configuration registers
  logic [mlfd_pkg::MagicW-1:0]  begin_magic_q;
  logic [mlfd_pkg::MagicW-1:0]  end_magic_q;
  logic [mlfd_pkg::MaxLenW-1:0] max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_magic_q <= '0;
      end_magic_q   <= '0;
      max_len_q     <= mlfd_pkg::MaxLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlfd_pkg::CFG_BEGIN_MAGIC: begin_magic_q <= cfg_data_i;
        mlfd_pkg::CFG_END_MAGIC:   end_magic_q   <= cfg_data_i;
        mlfd_pkg::CFG_MAX_LENGTH:  max_len_q     <= cfg_data_i[mlfd_pkg::MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  // Deframer state
  phase_e                       phase_q, phase_d;
  logic [mlfd_pkg::MagicW-1:0]  window_q, window_d;
  logic [mlfd_pkg::MaxLenW-1:0] len_left_q, len_left_d;
  logic [1:0]                   field_cnt_q, field_cnt_d;
  logic [mlfd_pkg::ByteW-1:0]   held_type_q, held_type_d;

  // Output register and skid register
  mlfd_pkg::result_t out_q, skid_q, res_c;
  logic              out_vld_q, skid_vld_q;
  logic              res_vld_c;

  logic in_fire, out_pop;
  assign in_i.ready = !skid_vld_q;
  assign in_fire    = in_i.valid && !skid_vld_q;
  assign out_pop    = out_vld_q && out_o.ready;

  // Length limit: smaller of register and build ceiling
  logic [mlfd_pkg::MagicW-1:0] max_len_ext, limit_c, shifted_c;
  assign max_len_ext = mlfd_pkg::MagicW'(max_len_q);
  assign limit_c     = (FrameLenCap < max_len_ext) ? FrameLenCap : max_len_ext;
  assign shifted_c   = {window_q[mlfd_pkg::MagicW-mlfd_pkg::ByteW-1:0], in_i.byte_in};

  // Phase logic for one byte
  always_comb begin
    phase_d     = phase_q;
    window_d    = window_q;
    len_left_d  = len_left_q;
    field_cnt_d = field_cnt_q;
    held_type_d = held_type_q;
    res_vld_c   = 1'b0;
    res_c       = '0;
    unique case (phase_q)
      PH_LEN: begin
        window_d = shifted_c;
        if (field_cnt_q != 2'd3) begin
          field_cnt_d = field_cnt_q + 2'd1;
        end else if (shifted_c == '0 || shifted_c > limit_c) begin
          phase_d          = PH_HUNT;
          window_d         = '0;
          field_cnt_d      = '0;
          res_vld_c        = 1'b1;
          res_c.kind       = mlfd_pkg::KIND_BAD_LEN;
          res_c.frame_end  = 1'b1;
        end else begin
          // limit keeps the length within the 17-bit counter
          len_left_d  = mlfd_pkg::MaxLenW'(shifted_c - 32'd1);
          window_d    = '0;
          field_cnt_d = '0;
          phase_d     = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_d = in_i.byte_in;
        phase_d     = (len_left_q == '0) ? PH_ENDMAG : PH_PAYLOAD;
        field_cnt_d = '0;
        window_d    = '0;
      end
      PH_PAYLOAD: begin
        res_vld_c        = 1'b1;
        res_c.kind       = mlfd_pkg::KIND_PAYLOAD;
        res_c.value      = in_i.byte_in;
        res_c.frame_type = held_type_q;
        len_left_d       = len_left_q - mlfd_pkg::MaxLenW'(1);
        if (len_left_q == mlfd_pkg::MaxLenW'(1)) begin
          phase_d     = PH_ENDMAG;
          field_cnt_d = '0;
          window_d    = '0;
        end
      end
      PH_ENDMAG: begin
        window_d = shifted_c;
        if (field_cnt_q != 2'd3) begin
          field_cnt_d = field_cnt_q + 2'd1;
        end else begin
          phase_d          = PH_HUNT;
          window_d         = '0;
          field_cnt_d      = '0;
          res_vld_c        = 1'b1;
          res_c.kind       = (shifted_c == end_magic_q) ? mlfd_pkg::KIND_GOOD
                                                        : mlfd_pkg::KIND_MISMATCH;
          res_c.frame_type = held_type_q;
          res_c.frame_end  = 1'b1;
        end
      end
      default: begin
        window_d = shifted_c;
        if (field_cnt_q != 2'd3) begin
          field_cnt_d = field_cnt_q + 2'd1;
        end else if (shifted_c == begin_magic_q) begin
          phase_d     = PH_LEN;
          window_d    = '0;
          field_cnt_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      window_q    <= '0;
      len_left_q  <= '0;
      field_cnt_q <= '0;
      held_type_q <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      window_q    <= window_d;
      len_left_q  <= len_left_d;
      field_cnt_q <= field_cnt_d;
      held_type_q <= held_type_d;
    end
  end

  // Result word registers: skid catches a word while the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_pop) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire && res_vld_c) begin
      if (out_vld_q && !out_pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_vld_c) begin
      if (out_vld_q && !out_pop) begin
        skid_q <= res_c;
      end else begin
        out_q <= res_c;
      end
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.value      = out_q.value;
  assign out_o.frame_type = out_q.frame_type;
  assign out_o.frame_end  = out_q.frame_end;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
      skid_vld_q |-> out_vld_q)
    else $error("skid word held with empty output register");

  a_skid_load_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(skid_vld_q) |-> $past(out_vld_q && !out_o.ready))
    else $error("skid loaded while output was free");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PH_PAYLOAD) |-> (len_left_q != '0))
    else $error("payload phase with no bytes left");

  a_body_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (phase_q == PH_TYPE || phase_q == PH_PAYLOAD) |->
        (window_q == '0 && field_cnt_q == '0))
    else $error("window not cleared inside frame body");

  a_end_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_fire && phase_q == PH_ENDMAG && field_cnt_q == 2'd3) |=>
        (phase_q == PH_HUNT))
    else $error("hunt not resumed after end word");

endmodule

`default_nettype wire
